// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by scalar_to_color_map
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is low
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/scm_pkg.sv -----
// register indexes and map codes for the scalar to color map
`timescale 1ns / 1ps

package scm_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN  = 2'd0,
        CFG_RANGE_MAX  = 2'd1,
        CFG_MAP_SELECT = 2'd2
    } t_cfg_idx;

    localparam logic MAP_JET     = 1'b0;
    localparam logic MAP_RAINBOW = 1'b1;

    localparam int LEVEL_W = 8;

endpackage

// ----- hw/rtl/scalar_to_color_map.sv -----
// scalar to rgb color map: range normalize, pipelined divider, jet or rainbow map
//
//  channel   | ports                                        | transaction when
//  ----------+----------------------------------------------+--------------------------
//  sample in | i_start, o_busy, i_sample_value              | i_start && !o_busy
//  color out | o_done, o_red_level, o_green_level, o_blue_l | o_done (one cycle)
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data   | i_cfg_valid && o_cfg_ready
//
//  one sample per cycle; the color transaction follows the range stage, divider stages and output register
//  the divider yields one quotient bit per pipeline stage
//  synchronous active-low reset clears the valid bits and loads the register defaults
//  o_busy stays low and the pipeline never stalls, since results cannot be held off
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scalar_to_color_map #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [VALUE_WIDTH-1:0]     i_sample_value,
    output logic                              o_done,
    output logic [scm_pkg::LEVEL_W-1:0]       o_red_level,
    output logic [scm_pkg::LEVEL_W-1:0]       o_green_level,
    output logic [scm_pkg::LEVEL_W-1:0]       o_blue_level,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]            i_cfg_data
);
    import scm_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = FRAC_BITS + 11;

    localparam logic [NW-1:0] ONE = NW'(1) << F;
    localparam logic [NW-1:0] E1  = ONE >> 3;
    localparam logic [NW-1:0] E3  = NW'(3) * (ONE >> 3);
    localparam logic [NW-1:0] E5  = NW'(5) * (ONE >> 3);
    localparam logic [NW-1:0] E7  = NW'(7) * (ONE >> 3);
    localparam logic [NW-1:0] Q1  = ONE >> 2;
    localparam logic [NW-1:0] Q2  = ONE >> 1;
    localparam logic [NW-1:0] Q3  = NW'(3) * (ONE >> 2);

    // configuration registers
    logic signed [W-1:0] r_range_min;
    logic signed [W-1:0] r_range_max;
    logic                r_map_select;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min  <= '0;
            r_range_max  <= W'(1) << F;
            r_map_select <= MAP_JET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RANGE_MIN:  r_range_min  <= i_cfg_data;
                CFG_RANGE_MAX:  r_range_max  <= i_cfg_data;
                CFG_MAP_SELECT: r_map_select <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline: index 0 is the range stage, 1..F are divider stages
    logic         r_vld  [0:F];
    logic [W-1:0] r_rem  [0:F];
    logic [W-1:0] r_span [0:F];
    logic [F-1:0] r_quo  [0:F];
    logic         r_zero [0:F];
    logic         r_one  [0:F];
    logic         r_msel [0:F];

    logic         n_zero;
    logic         n_one;

    always_comb begin
        n_zero = (r_range_max <= r_range_min) || (i_sample_value <= r_range_min);
        n_one  = !n_zero && (i_sample_value >= r_range_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= W'(i_sample_value - r_range_min);
        r_span[0] <= W'(r_range_max - r_range_min);
        r_quo[0]  <= '0;
        r_zero[0] <= n_zero;
        r_one[0]  <= n_one;
        r_msel[0] <= r_map_select;
    end

    for (genvar k = 0; k < F; k++) begin : g_div
        logic [W:0] w_d2;
        logic       w_ge;

        // remainder stays below span, so it fits W bits after each step
        assign w_d2 = {r_rem[k], 1'b0};
        assign w_ge = (w_d2 >= {1'b0, r_span[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= w_ge ? W'(w_d2 - {1'b0, r_span[k]}) : w_d2[W-1:0];
            r_span[k+1] <= r_span[k];
            r_quo[k+1]  <= {r_quo[k][F-2:0], w_ge};
            r_zero[k+1] <= r_zero[k];
            r_one[k+1]  <= r_one[k];
            r_msel[k+1] <= r_msel[k];
        end
    end

    // color map stage, numerators in units of 2^-F
    logic [NW-1:0] w_t;
    logic [NW-1:0] w_num_r;
    logic [NW-1:0] w_num_g;
    logic [NW-1:0] w_num_b;

    always_comb begin
        if (r_one[F]) begin
            w_t = ONE;
        end else if (r_zero[F]) begin
            w_t = '0;
        end else begin
            w_t = NW'(r_quo[F]);
        end

        if (r_msel[F] == MAP_RAINBOW) begin
            if (w_t < Q1) begin
                w_num_r = '0;
                w_num_g = NW'(1020) * w_t;
                w_num_b = NW'(255) * ONE;
            end else if (w_t < Q2) begin
                w_num_r = '0;
                w_num_g = NW'(255) * ONE;
                w_num_b = NW'(1020) * (Q2 - w_t);
            end else if (w_t < Q3) begin
                w_num_r = NW'(1020) * (w_t - Q2);
                w_num_g = NW'(255) * ONE;
                w_num_b = '0;
            end else begin
                w_num_r = NW'(255) * ONE;
                w_num_g = NW'(1020) * (ONE - w_t);
                w_num_b = '0;
            end
        end else begin
            if (w_t < E1) begin
                w_num_r = '0;
                w_num_g = '0;
                w_num_b = NW'(255) * ((ONE >> 1) + (w_t << 2));
            end else if (w_t < E3) begin
                w_num_r = '0;
                w_num_g = NW'(1020) * (w_t - E1);
                w_num_b = NW'(255) * ONE;
            end else if (w_t < E5) begin
                w_num_r = NW'(816) * (w_t - E3);
                w_num_g = NW'(255) * ONE;
                w_num_b = NW'(255) * ONE - NW'(1020) * (w_t - E3);
            end else if (w_t < E7) begin
                // red holds its 0.8 peak
                w_num_r = NW'(204) * ONE;
                w_num_g = NW'(255) * ONE - NW'(1020) * (w_t - E5);
                w_num_b = '0;
            end else begin
                w_num_r = NW'(204) * ONE - NW'(1020) * (w_t - E7);
                w_num_g = '0;
                w_num_b = '0;
            end
        end
    end

    logic               r_out_vld;
    logic               r_out_msel;
    logic [LEVEL_W-1:0] r_red;
    logic [LEVEL_W-1:0] r_green;
    logic [LEVEL_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[F];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_msel <= r_msel[F];
        r_red      <= w_num_r[F +: LEVEL_W];
        r_green    <= w_num_g[F +: LEVEL_W];
        r_blue     <= w_num_b[F +: LEVEL_W];
    end

    assign o_done        = r_out_vld;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;

    `ASSERT_AT(a_latency, i_clk, i_rst_n, (i_start && !o_busy) |-> ##(FRAC_BITS+2) o_done, "color missing after sample transaction")
    `ASSERT_AT(a_rem_bound, i_clk, i_rst_n, (r_vld[F] && !r_zero[F] && !r_one[F]) |-> (r_rem[F] < r_span[F]), "divider remainder not below span")
    `ASSERT_NEVER(a_rainbow_mix, i_clk, i_rst_n, o_done && (r_out_msel == MAP_RAINBOW) && (o_red_level != '0) && (o_blue_level != '0), "rainbow color with red and blue")

endmodule
